>>> hw/rtl/ttt_pkg.sv
// Shared types, codes and constants of the target track table.
// Used by ttt_ctrl, ttt_dp and the top module; depends on nothing.
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int COORD_BITS_DEF  = 12;

  localparam int FRAME_W     = 13;
  localparam int GATE_W      = 12;
  localparam int LIFE_W      = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int ACTION_W    = 3;
  localparam int SLOT_W      = 5;
  localparam int COUNT_OUT_W = 6;

  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 13'd480;
  localparam logic [GATE_W-1:0]  NEAR_DIST_RST    = 12'd100;
  localparam logic [LIFE_W-1:0]  LIFE_START_RST   = 8'd10;

  localparam int EDGE_LOW  = 1;
  localparam int EDGE_HIGH = 5;

  typedef enum logic [1:0] {
    CMD_FRAME_START = 2'd0,
    CMD_BOX         = 2'd1,
    CMD_FRAME_END   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_NEAR_DIST    = 2'd2,
    CFG_LIFE_START   = 2'd3
  } cfg_idx_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FRAME_START = 3'd0,
    ACT_FRAME_END   = 3'd1,
    ACT_ADDED       = 3'd2,
    ACT_UPDATED     = 3'd3,
    ACT_REMOVED     = 3'd4,
    ACT_REJECTED    = 3'd5,
    ACT_NOT_ADDED   = 3'd6
  } act_e;

  typedef enum logic [3:0] {
    OP_NONE   = 4'd0,
    OP_LOAD   = 4'd1,
    OP_DEC    = 4'd2,
    OP_PURGE  = 4'd3,
    OP_SCAN   = 4'd4,
    OP_APPLY  = 4'd5,
    OP_SHIFT  = 4'd6,
    OP_FINISH = 4'd7
  } op_e;

  typedef struct packed {
    op_e  op;
    act_e act;
  } ctrl_cmd_t;

  typedef struct packed {
    logic done;
    logic shape_ok;
    logic found;
    logic interior;
    logic add_ok;
  } ctrl_stat_t;

endpackage

>>> hw/rtl/ttt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/ttt_ctrl.sv
// Sequencer of the target track table: walks each command through its phases.
// Depends on ttt_pkg; drives ttt_dp through ctrl_cmd_t, reads ctrl_stat_t.
`timescale 1ns / 1ps

module ttt_ctrl import ttt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] cmd_i,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  ctrl_o,
  output logic       busy_o
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DEC    = 7'b0000010,
    S_PURGE  = 7'b0000100,
    S_SCAN   = 7'b0001000,
    S_APPLY  = 7'b0010000,
    S_SHIFT  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  act_e   act_q, act_d;

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    ctrl_o.op   = OP_NONE;
    ctrl_o.act  = act_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.op = OP_LOAD;
          case (cmd_e'(cmd_i))
            CMD_FRAME_START: begin
              state_d = S_DEC;
              act_d   = ACT_FRAME_START;
            end
            CMD_FRAME_END: begin
              state_d = S_PURGE;
              act_d   = ACT_FRAME_END;
            end
            CMD_BOX: state_d = S_SCAN;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_DEC: begin
        ctrl_o.op = OP_DEC;
        if (stat_i.done) state_d = S_FINISH;
      end
      S_PURGE: begin
        ctrl_o.op = OP_PURGE;
        if (stat_i.done) state_d = S_FINISH;
      end
      S_SCAN: begin
        if (!stat_i.shape_ok) begin
          act_d   = ACT_REJECTED;
          state_d = S_FINISH;
        end else begin
          ctrl_o.op = OP_SCAN;
          if (stat_i.done) state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        ctrl_o.op = OP_APPLY;
        if (stat_i.found && stat_i.interior) begin
          act_d   = ACT_UPDATED;
          state_d = S_FINISH;
        end else if (stat_i.found) begin
          act_d   = ACT_REMOVED;
          state_d = S_SHIFT;
        end else if (stat_i.add_ok) begin
          act_d   = ACT_ADDED;
          state_d = S_FINISH;
        end else begin
          act_d   = ACT_NOT_ADDED;
          state_d = S_FINISH;
        end
      end
      S_SHIFT: begin
        ctrl_o.op = OP_SHIFT;
        if (stat_i.done) state_d = S_FINISH;
      end
      S_FINISH: begin
        ctrl_o.op = OP_FINISH;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_FRAME_START;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_finish_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FINISH |=> state_q == S_IDLE)
    else $error("finish phase not followed by idle");

  a_unused_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cmd_i == 2'd3) |=> state_q == S_IDLE)
    else $error("unused command left the sequencer busy");

  a_apply_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_APPLY |-> $past(state_q) == S_SCAN)
    else $error("apply phase entered without a scan");

endmodule

>>> hw/rtl/ttt_dp.sv
// Datapath of the target track table: registers, clip and shape logic, entry RAM
// streaming for life decrement, purge, nearest-entry scan and compaction.
// Depends on ttt_pkg and ttt_ram.
`timescale 1ns / 1ps

module ttt_dp import ttt_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctrl_cmd_t              ctrl_i,
  output ctrl_stat_t             stat_o,
  input  logic [1:0]             cmd_i,
  input  logic [COORD_BITS-1:0]  box_x_i,
  input  logic [COORD_BITS-1:0]  box_y_i,
  input  logic [COORD_BITS-1:0]  box_w_i,
  input  logic [COORD_BITS-1:0]  box_h_i,
  input  logic                   allow_new_i,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   done_o,
  output logic [ACTION_W-1:0]    action_o,
  output logic [SLOT_W-1:0]      slot_o,
  output logic [COUNT_OUT_W-1:0] entry_count_o,
  output logic [COUNT_OUT_W-1:0] purged_o
);

  localparam int IW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);
  localparam int FW   = ((COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W) + 2;
  localparam int GW   = ((COORD_BITS > GATE_W) ? COORD_BITS : GATE_W) + 2;
  localparam int PW   = COORD_BITS + 4;
  localparam int EW   = 4 * COORD_BITS + LIFE_W;

  // configuration
  logic [FRAME_W-1:0] fw_q, fh_q;
  logic [GATE_W-1:0]  gate_q;
  logic [LIFE_W-1:0]  life_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q         <= FRAME_WIDTH_RST;
      fh_q         <= FRAME_HEIGHT_RST;
      gate_q       <= NEAR_DIST_RST;
      life_start_q <= LIFE_START_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  fw_q         <= cfg_data_i[FRAME_W-1:0];
        CFG_FRAME_HEIGHT: fh_q         <= cfg_data_i[FRAME_W-1:0];
        CFG_NEAR_DIST:    gate_q       <= cfg_data_i[GATE_W-1:0];
        CFG_LIFE_START:   life_start_q <= cfg_data_i[LIFE_W-1:0];
        default: ;
      endcase
    end
  end

  // clip, shape and border test on the incoming box
  logic signed [FW-1:0] x_s, y_s, w_s, h_s, fw_s, fh_s, cw_s, ch_s, wc_s, hc_s;
  logic [COORD_BITS-1:0] wu, hu;
  logic [PW-1:0] w10, h3;
  logic pos_w, pos_h, shape_ok_in, inside_in;

  always_comb begin
    x_s  = $signed(FW'(box_x_i));
    y_s  = $signed(FW'(box_y_i));
    w_s  = $signed(FW'(box_w_i));
    h_s  = $signed(FW'(box_h_i));
    fw_s = $signed(FW'(fw_q));
    fh_s = $signed(FW'(fh_q));
    cw_s = fw_s - x_s;
    ch_s = fh_s - y_s;
    wc_s = (cw_s < w_s) ? cw_s : w_s;
    hc_s = (ch_s < h_s) ? ch_s : h_s;
    pos_w = wc_s > $signed(FW'(0));
    pos_h = hc_s > $signed(FW'(0));
    wu  = wc_s[COORD_BITS-1:0];
    hu  = hc_s[COORD_BITS-1:0];
    w10 = PW'(wu) * PW'(10);
    h3  = PW'(hu) * PW'(3);
    shape_ok_in = pos_w && pos_h && !(w10 < h3) &&
                  !({1'b0, wu} > {hu, 1'b0});
    inside_in = (x_s > $signed(FW'(EDGE_LOW))) && (y_s > $signed(FW'(EDGE_LOW))) &&
                (x_s + wc_s < fw_s - $signed(FW'(EDGE_HIGH))) &&
                (y_s + hc_s < fh_s - $signed(FW'(EDGE_HIGH)));
  end

  // item registers
  logic [COORD_BITS-1:0] bx_q, by_q, bw_q, bh_q;
  logic shape_ok_q, inside_q, allow_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_LOAD) begin
      bx_q       <= box_x_i;
      by_q       <= box_y_i;
      bw_q       <= wu;
      bh_q       <= hu;
      shape_ok_q <= shape_ok_in && (cmd_e'(cmd_i) == CMD_BOX);
      inside_q   <= inside_in;
      allow_q    <= allow_new_i;
    end
  end

  // entry RAM
  logic          we;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  ttt_ram #(.WIDTH(EW), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  logic [COORD_BITS-1:0] ex, ey;
  logic [LIFE_W-1:0]     elife;
  assign ex    = rdata[EW-1 -: COORD_BITS];
  assign ey    = rdata[EW-1-COORD_BITS -: COORD_BITS];
  assign elife = rdata[LIFE_W-1:0];

  // control state of the datapath
  logic [CNTW-1:0] count_q, count_d, rd_q, rd_d, wr_q, wr_d, purged_q, purged_d;
  logic            pend_q, pend_d, found_q, found_d;
  logic [IW-1:0]   pidx_q, pidx_d, best_pos_q, best_pos_d, slot_q, slot_d;
  logic [COORD_BITS:0] best_q, best_d;
  logic            valid_q, valid_d;

  // output payload
  logic [ACTION_W-1:0]    out_act_q;
  logic [SLOT_W-1:0]      out_slot_q;
  logic [COUNT_OUT_W-1:0] out_count_q, out_purged_q;

  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS:0]   dist_sum;
  logic                  near, stream;

  always_comb begin
    dx       = (bx_q > ex) ? bx_q - ex : ex - bx_q;
    dy       = (by_q > ey) ? by_q - ey : ey - by_q;
    dist_sum = {1'b0, dx} + {1'b0, dy};
    near = !(GW'(dx) > GW'(gate_q)) && !(GW'(dy) > GW'(gate_q));
    stream = (ctrl_i.op == OP_DEC) || (ctrl_i.op == OP_PURGE) ||
             (ctrl_i.op == OP_SCAN) || (ctrl_i.op == OP_SHIFT);
  end

  always_comb begin
    count_d    = count_q;
    rd_d       = rd_q;
    wr_d       = wr_q;
    purged_d   = purged_q;
    pend_d     = 1'b0;
    pidx_d     = pidx_q;
    found_d    = found_q;
    best_d     = best_q;
    best_pos_d = best_pos_q;
    slot_d     = slot_q;
    valid_d    = 1'b0;
    we         = 1'b0;
    waddr      = pidx_q;
    wdata      = rdata;
    raddr      = rd_q[IW-1:0];

    if (stream && (rd_q < count_q)) begin
      rd_d   = rd_q + CNTW'(1);
      pend_d = 1'b1;
      pidx_d = rd_q[IW-1:0];
    end

    case (ctrl_i.op)
      OP_LOAD: begin
        rd_d     = '0;
        wr_d     = '0;
        purged_d = '0;
        found_d  = 1'b0;
        pend_d   = 1'b0;
      end
      OP_DEC: begin
        if (pend_q) begin
          we    = 1'b1;
          wdata = {rdata[EW-1:LIFE_W],
                   (elife != '0) ? elife - LIFE_W'(1) : elife};
        end
      end
      OP_PURGE: begin
        if (pend_q) begin
          if (elife != '0) begin
            we    = 1'b1;
            waddr = wr_q[IW-1:0];
            wr_d  = wr_q + CNTW'(1);
          end else begin
            purged_d = purged_q + CNTW'(1);
          end
        end
      end
      OP_SCAN: begin
        // lowest position wins a tie
        if (pend_q && near && (!found_q || dist_sum < best_q)) begin
          found_d    = 1'b1;
          best_d     = dist_sum;
          best_pos_d = pidx_q;
        end
      end
      OP_APPLY: begin
        wdata = {bx_q, by_q, bw_q, bh_q, life_start_q};
        if (found_q) begin
          slot_d = best_pos_q;
          if (inside_q) begin
            we    = 1'b1;
            waddr = best_pos_q;
          end
          rd_d = CNTW'(best_pos_q) + CNTW'(1);
        end else begin
          slot_d = count_q[IW-1:0];
          if (stat_o.add_ok) begin
            we      = 1'b1;
            waddr   = count_q[IW-1:0];
            count_d = count_q + CNTW'(1);
          end
        end
      end
      OP_SHIFT: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = pidx_q - IW'(1);
        end
      end
      OP_FINISH: begin
        valid_d = 1'b1;
        if (ctrl_i.act == ACT_REMOVED) count_d = count_q - CNTW'(1);
        if (ctrl_i.act == ACT_FRAME_END) count_d = wr_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
      valid_q <= 1'b0;
      rd_q    <= '0;
      wr_q    <= '0;
      found_q <= 1'b0;
    end else begin
      count_q <= count_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
      rd_q    <= rd_d;
      wr_q    <= wr_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    purged_q   <= purged_d;
    pidx_q     <= pidx_d;
    best_q     <= best_d;
    best_pos_q <= best_pos_d;
    slot_q     <= slot_d;
    if (ctrl_i.op == OP_FINISH) begin
      out_act_q    <= ctrl_i.act;
      out_count_q  <= COUNT_OUT_W'(count_d);
      out_slot_q   <= ((ctrl_i.act == ACT_ADDED) || (ctrl_i.act == ACT_UPDATED) ||
                       (ctrl_i.act == ACT_REMOVED)) ? SLOT_W'(slot_q) : '0;
      out_purged_q <= (ctrl_i.act == ACT_FRAME_END) ? COUNT_OUT_W'(purged_q) : '0;
    end
  end

  assign stat_o.done     = (rd_q >= count_q) && !pend_q;
  assign stat_o.shape_ok = shape_ok_q;
  assign stat_o.found    = found_q;
  assign stat_o.interior = inside_q;
  assign stat_o.add_ok   = allow_q && inside_q && (count_q < CNTW'(MAX_ENTRIES));

  assign done_o        = valid_q;
  assign action_o      = out_act_q;
  assign slot_o        = out_slot_q;
  assign entry_count_o = out_count_q;
  assign purged_o      = out_purged_q;

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held longer than one cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(MAX_ENTRIES))
    else $error("entry count beyond table depth");

  a_purge_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.op == OP_PURGE |-> wr_q + purged_q <= count_q)
    else $error("purge lost track of entries");

endmodule

>>> hw/rtl/target_track_table_top.sv
// Target track table: a compacted table of tracked boxes with life counts.
// Results: frame start, frame end, shape reject, box update or add, box removal.
// One item at a time; busy_o is high until the result strobe. The entry RAM
// port paces each sweep at one entry a cycle. Reset clears the count and the control
// registers only; entries are written before they are read, no clearing pass.
// Depends on ttt_pkg, ttt_ctrl, ttt_dp and ttt_ram.
`timescale 1ns / 1ps

module target_track_table_top import ttt_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int COORD_BITS  = COORD_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [1:0]             cmd_i,
  input  logic [COORD_BITS-1:0]  box_x_i,
  input  logic [COORD_BITS-1:0]  box_y_i,
  input  logic [COORD_BITS-1:0]  box_w_i,
  input  logic [COORD_BITS-1:0]  box_h_i,
  input  logic                   allow_new_i,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output logic                   done_o,
  output logic [ACTION_W-1:0]    action_o,
  output logic [SLOT_W-1:0]      slot_o,
  output logic [COUNT_OUT_W-1:0] entry_count_o,
  output logic [COUNT_OUT_W-1:0] purged_o
);

  ctrl_cmd_t  ctrl;
  ctrl_stat_t stat;
  logic       busy;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = busy;

  ttt_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .cmd_i   (cmd_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  ttt_dp #(.MAX_ENTRIES(MAX_ENTRIES), .COORD_BITS(COORD_BITS)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cmd_i         (cmd_i),
    .box_x_i       (box_x_i),
    .box_y_i       (box_y_i),
    .box_w_i       (box_w_i),
    .box_h_i       (box_h_i),
    .allow_new_i   (allow_new_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .done_o        (done_o),
    .action_o      (action_o),
    .slot_o        (slot_o),
    .entry_count_o (entry_count_o),
    .purged_o      (purged_o)
  );

endmodule
